@@ src/i2cmts_pkg.sv @@
// Shared codes, types and the control program of the I2C transfer sequencer.
`timescale 1ns / 1ps
package i2cmts_pkg;

    typedef logic [2:0] t_pc;

    // Input opcodes
    localparam logic [2:0] OP_POLL    = 3'd0;
    localparam logic [2:0] OP_ENQUEUE = 3'd1;
    localparam logic [2:0] OP_INSTANT = 3'd2;
    localparam logic [2:0] OP_EVENT   = 3'd3;
    localparam logic [2:0] OP_REPLY   = 3'd4;

    // Bus status codes
    localparam logic [3:0] BS_START   = 4'd0;
    localparam logic [3:0] BS_RESTART = 4'd1;
    localparam logic [3:0] BS_SLAR_ACK = 4'd2;
    localparam logic [3:0] BS_SLAW_ACK = 4'd3;
    localparam logic [3:0] BS_RX_ACK  = 4'd4;
    localparam logic [3:0] BS_RX_NACK = 4'd5;
    localparam logic [3:0] BS_TX_ACK  = 4'd6;
    localparam logic [3:0] BS_TX_NACK = 4'd7;

    // Client status codes
    localparam logic [2:0] ST_RX_FAIL  = 3'd0;
    localparam logic [2:0] ST_TX_FAIL  = 3'd1;
    localparam logic [2:0] ST_RX_READY = 3'd2;
    localparam logic [2:0] ST_BYTE_RX  = 3'd3;
    localparam logic [2:0] ST_LAST_RX  = 3'd4;
    localparam logic [2:0] ST_TX_READY = 3'd5;
    localparam logic [2:0] ST_BYTE_TX  = 3'd6;
    localparam logic [2:0] ST_NACK     = 3'd7;

    // Bus commands
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_SEND    = 3'd1;
    localparam logic [2:0] CMD_RX_ACK  = 3'd2;
    localparam logic [2:0] CMD_RX_NACK = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_ENQ    = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_CMD    = 2'd2;

    // Transfer phase; bit 3 marks a pending client reply
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_SLA_R      = 4'd1;
    localparam logic [3:0] PH_SLA_W      = 4'd2;
    localparam logic [3:0] PH_SLA_R_SENT = 4'd3;
    localparam logic [3:0] PH_SLA_W_SENT = 4'd4;
    localparam logic [3:0] PH_READ       = 4'd5;
    localparam logic [3:0] PH_WRITE      = 4'd6;
    localparam logic [3:0] PH_CLOSING    = 4'd7;
    localparam logic [3:0] PH_WAIT       = 4'd8;

    // Micro-operations
    localparam logic [2:0] UOP_DISPATCH = 3'd0;
    localparam logic [2:0] UOP_POLL     = 3'd1;
    localparam logic [2:0] UOP_SCAN     = 3'd2;
    localparam logic [2:0] UOP_INSTANT  = 3'd3;
    localparam logic [2:0] UOP_EVENT    = 3'd4;
    localparam logic [2:0] UOP_REPLY    = 3'd5;
    localparam logic [2:0] UOP_FINISH   = 3'd6;
    localparam logic [2:0] UOP_NOP      = 3'd7;

    // Branch conditions; a step whose condition fails ends the item
    localparam logic [2:0] COND_NONE      = 3'd0;
    localparam logic [2:0] COND_OPCODE    = 3'd1;
    localparam logic [2:0] COND_SCAN_MORE = 3'd2;
    localparam logic [2:0] COND_EV_CLOSE  = 3'd3;
    localparam logic [2:0] COND_WAITING   = 3'd4;

    // Program addresses
    localparam t_pc PC_DISPATCH = 3'd0;
    localparam t_pc PC_POLL     = 3'd1;
    localparam t_pc PC_SCAN     = 3'd2;
    localparam t_pc PC_INSTANT  = 3'd3;
    localparam t_pc PC_EVENT    = 3'd4;
    localparam t_pc PC_REPLY    = 3'd5;
    localparam t_pc PC_FINISH   = 3'd6;

    typedef struct packed {
        logic [2:0] uop;
        logic [2:0] cond;
        t_pc        branch;
        logic       emits;
    } t_uword;

    function automatic t_uword uc_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_DISPATCH: w = '{uop: UOP_DISPATCH, cond: COND_OPCODE,
                               branch: PC_DISPATCH, emits: 1'b0};
            PC_POLL:     w = '{uop: UOP_POLL, cond: COND_NONE,
                               branch: PC_DISPATCH, emits: 1'b1};
            PC_SCAN:     w = '{uop: UOP_SCAN, cond: COND_SCAN_MORE,
                               branch: PC_SCAN, emits: 1'b1};
            PC_INSTANT:  w = '{uop: UOP_INSTANT, cond: COND_NONE,
                               branch: PC_DISPATCH, emits: 1'b0};
            PC_EVENT:    w = '{uop: UOP_EVENT, cond: COND_EV_CLOSE,
                               branch: PC_FINISH, emits: 1'b1};
            PC_REPLY:    w = '{uop: UOP_REPLY, cond: COND_WAITING,
                               branch: PC_FINISH, emits: 1'b0};
            PC_FINISH:   w = '{uop: UOP_FINISH, cond: COND_NONE,
                               branch: PC_DISPATCH, emits: 1'b1};
            default:     w = '{uop: UOP_NOP, cond: COND_NONE,
                               branch: PC_DISPATCH, emits: 1'b0};
        endcase
        return w;
    endfunction

    function automatic t_pc entry_pc(input logic [2:0] op);
        t_pc pc;
        unique case (op)
            OP_POLL:    pc = PC_POLL;
            OP_ENQUEUE: pc = PC_SCAN;
            OP_INSTANT: pc = PC_INSTANT;
            OP_EVENT:   pc = PC_EVENT;
            OP_REPLY:   pc = PC_REPLY;
            default:    pc = PC_DISPATCH;
        endcase
        return pc;
    endfunction

endpackage

@@ src/i2c_master_transfer_sequencer_core.sv @@
// Microcoded I2C master transfer sequencer with a ring of transfer requests.
// Steps per item: poll, instant and plain bus event items run accept, dispatch and one step;
// a closing-read event and a client reply to a pending status add a finish step; an enqueue
// scans one slot per cycle while the output register is not full. The result is registered,
// and a full output register stalls an emitting step.
// Sync active-low reset clears phase, slot valid bits, head, flags and held status.
`timescale 1ns / 1ps
module i2c_master_transfer_sequencer_core
    import i2cmts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_opcode,
    input  logic [6:0] i_address,
    input  logic       i_is_transmit,
    input  logic [3:0] i_client_tag,
    input  logic       i_bus_idle,
    input  logic [3:0] i_bus_status,
    input  logic [7:0] i_rx_byte,
    input  logic       i_keep_going,
    input  logic       i_has_tx_byte,
    input  logic [7:0] i_tx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_result_kind,
    output logic       o_accepted,
    output logic [3:0] o_target_tag,
    output logic [2:0] o_client_status,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_bus_command,
    output logic       o_last
);

    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam logic [HW-1:0] IDX_LAST = HW'(QUEUE_DEPTH - 1);

    // Sequencer
    logic            r_busy;
    t_pc             r_pc;
    t_uword          w;
    logic            step_en;
    logic            take;
    t_pc             target;

    // Latched input item
    logic [2:0]      r_opcode;
    logic [6:0]      r_address;
    logic            r_is_transmit;
    logic [3:0]      r_tag;
    logic            r_bus_idle;
    logic [3:0]      r_bus_status;
    logic [7:0]      r_rx_byte;
    logic            r_keep;
    logic            r_has_tx;
    logic [7:0]      r_tx_byte;

    // Transfer state
    logic [3:0]             r_phase, n_phase;
    logic [QUEUE_DEPTH-1:0] r_slot_valid, n_slot_valid;
    logic [7:0]             r_slot_addr_dir [QUEUE_DEPTH];
    logic [3:0]             r_slot_client [QUEUE_DEPTH];
    logic [HW-1:0]          r_head, n_head;
    logic                   r_instant, n_instant;
    logic [2:0]             r_held_status, n_held_status;
    logic                   r_held_nack, n_held_nack;

    // Scan and finish operands
    logic [HW-1:0]   r_scan_ptr, n_scan_ptr;
    logic [HW-1:0]   r_scan_cnt, n_scan_cnt;
    logic            r_fin_closing, n_fin_closing;
    logic            r_fin_ret, n_fin_ret;
    logic            r_fin_nack, n_fin_nack;
    logic            r_fin_has_tx, n_fin_has_tx;
    logic [7:0]      r_fin_txb, n_fin_txb;

    // Slot write port
    logic            wr_en;
    logic [HW-1:0]   wr_idx;
    logic [7:0]      wr_addr_dir;

    // Emitted result
    logic            em;
    logic [1:0]      em_kind;
    logic            em_acc;
    logic [3:0]      em_tag;
    logic [2:0]      em_st;
    logic [7:0]      em_data;
    logic [2:0]      em_cmd;

    // Output register
    logic            r_out_valid;
    logic [1:0]      r_out_kind;
    logic            r_out_acc;
    logic [3:0]      r_out_tag;
    logic [2:0]      r_out_st;
    logic [7:0]      r_out_data;
    logic [2:0]      r_out_cmd;

    // Datapath helpers
    logic [7:0]      head_ad;
    logic            head_valid;
    logic [HW-1:0]   head_inc;
    logic [HW-1:0]   ptr_inc;
    logic            ev_skip;
    logic            c_opcode, c_scan_more, c_ev_close, c_waiting;
    logic [2:0]      ev_st;
    logic            ev_status;
    logic [3:0]      ev_phase;

    assign w        = uc_rom(r_pc);
    assign step_en  = r_busy && !(w.emits && r_out_valid && !i_out_ready);
    assign o_in_ready = !r_busy;

    assign head_ad    = r_slot_addr_dir[r_head];
    assign head_valid = r_slot_valid[r_head];
    assign head_inc   = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
    assign ptr_inc    = (r_scan_ptr == IDX_LAST) ? '0 : r_scan_ptr + 1'b1;
    assign wr_addr_dir = {r_address, ~r_is_transmit};

    assign ev_skip     = !head_valid || (r_phase == PH_IDLE) || r_phase[3];
    assign c_opcode    = (r_opcode <= OP_REPLY);
    assign c_scan_more = r_slot_valid[r_scan_ptr] && (r_scan_cnt != IDX_LAST);
    assign c_ev_close  = !ev_skip && (r_phase == PH_CLOSING);
    assign c_waiting   = r_phase[3];

    always_comb begin
        case (w.cond)
            COND_OPCODE:    take = c_opcode;
            COND_SCAN_MORE: take = c_scan_more;
            COND_EV_CLOSE:  take = c_ev_close;
            COND_WAITING:   take = c_waiting;
            default:        take = 1'b0;
        endcase
        target = (w.cond == COND_OPCODE) ? entry_pc(r_opcode) : w.branch;
    end

    // Status and next phase of a bus event, for the phase it arrives in
    always_comb begin
        ev_st     = ST_RX_FAIL;
        ev_status = 1'b1;
        ev_phase  = r_phase;
        unique case (r_phase) inside
            PH_SLA_R, PH_SLA_W: begin
                if (r_bus_status == BS_START || r_bus_status == BS_RESTART) begin
                    ev_status = 1'b0;
                    ev_phase  = (r_phase == PH_SLA_R) ? PH_SLA_R_SENT : PH_SLA_W_SENT;
                end else begin
                    ev_st = (r_phase == PH_SLA_R) ? ST_RX_FAIL : ST_TX_FAIL;
                end
            end
            PH_SLA_R_SENT: begin
                if (r_bus_status == BS_SLAR_ACK) begin
                    ev_st    = ST_RX_READY;
                    ev_phase = PH_READ;
                end
            end
            PH_SLA_W_SENT: begin
                ev_st = ST_TX_FAIL;
                if (r_bus_status == BS_SLAW_ACK) begin
                    ev_st    = ST_TX_READY;
                    ev_phase = PH_WRITE;
                end
            end
            PH_READ: begin
                if (r_bus_status == BS_RX_ACK) ev_st = ST_BYTE_RX;
                else if (r_bus_status == BS_RX_NACK) ev_st = ST_LAST_RX;
            end
            PH_WRITE: begin
                ev_st = ST_TX_FAIL;
                if (r_bus_status == BS_TX_ACK) ev_st = ST_BYTE_TX;
                else if (r_bus_status == BS_TX_NACK) ev_st = ST_NACK;
            end
            default: ev_status = 1'b0;
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_slot_valid  = r_slot_valid;
        n_head        = r_head;
        n_instant     = r_instant;
        n_held_status = r_held_status;
        n_held_nack   = r_held_nack;
        n_scan_ptr    = r_scan_ptr;
        n_scan_cnt    = r_scan_cnt;
        n_fin_closing = r_fin_closing;
        n_fin_ret     = r_fin_ret;
        n_fin_nack    = r_fin_nack;
        n_fin_has_tx  = r_fin_has_tx;
        n_fin_txb     = r_fin_txb;
        wr_en   = 1'b0;
        wr_idx  = r_head;
        em      = 1'b0;
        em_kind = KIND_CMD;
        em_acc  = 1'b0;
        em_tag  = 4'd0;
        em_st   = 3'd0;
        em_data = 8'd0;
        em_cmd  = 3'd0;
        if (step_en) begin
            unique case (w.uop)
                UOP_DISPATCH: begin
                    n_scan_ptr = r_head;
                    n_scan_cnt = '0;
                end
                UOP_POLL: begin
                    if (r_phase == PH_IDLE && r_bus_idle && head_valid) begin
                        n_phase = head_ad[0] ? PH_SLA_R : PH_SLA_W;
                        em      = 1'b1;
                        em_cmd  = CMD_START;
                    end
                end
                UOP_SCAN: begin
                    if (!r_slot_valid[r_scan_ptr]) begin
                        n_slot_valid[r_scan_ptr] = (r_tag != 4'd0);
                        wr_en   = 1'b1;
                        wr_idx  = r_scan_ptr;
                        em      = 1'b1;
                        em_kind = KIND_ENQ;
                        em_acc  = 1'b1;
                    end else if (r_scan_cnt == IDX_LAST) begin
                        em      = 1'b1;
                        em_kind = KIND_ENQ;
                    end else begin
                        n_scan_ptr = ptr_inc;
                        n_scan_cnt = r_scan_cnt + 1'b1;
                    end
                end
                UOP_INSTANT: begin
                    n_slot_valid[r_head] = (r_tag != 4'd0);
                    wr_en     = 1'b1;
                    n_instant = 1'b1;
                end
                UOP_EVENT: begin
                    if (c_ev_close) begin
                        // read already closed: finish without a status
                        n_fin_closing = 1'b1;
                        n_fin_ret     = 1'b0;
                        n_fin_nack    = (r_bus_status == BS_RX_NACK);
                        n_fin_has_tx  = 1'b0;
                    end else if (!ev_skip) begin
                        em = 1'b1;
                        if (ev_status) begin
                            n_held_status = ev_st;
                            n_held_nack   = (r_bus_status == BS_RX_NACK);
                            n_phase       = ev_phase | PH_WAIT;
                            em_kind = KIND_STATUS;
                            em_tag  = r_slot_client[r_head];
                            em_st   = ev_st;
                            if (ev_st == ST_BYTE_RX || ev_st == ST_LAST_RX) em_data = r_rx_byte;
                        end else begin
                            n_phase = ev_phase;
                            em_cmd  = CMD_SEND;
                            em_data = head_ad;
                        end
                    end
                end
                UOP_REPLY: begin
                    n_phase       = {1'b0, r_phase[2:0]};
                    n_fin_closing = (r_held_status == ST_RX_FAIL) ||
                                    (r_held_status == ST_TX_FAIL) ||
                                    (r_held_status == ST_LAST_RX) ||
                                    (r_held_status == ST_NACK);
                    n_fin_ret     = r_keep;
                    n_fin_nack    = r_held_nack;
                    n_fin_has_tx  = r_has_tx;
                    n_fin_txb     = r_tx_byte;
                end
                UOP_FINISH: begin
                    if (r_instant && (r_phase != PH_READ || r_fin_nack)) begin
                        // pending instant request: restart on the new head
                        n_phase   = head_ad[0] ? PH_SLA_R : PH_SLA_W;
                        n_instant = 1'b0;
                        em        = 1'b1;
                        em_cmd    = CMD_START;
                    end else if (!r_fin_ret && !r_fin_closing &&
                                 (r_phase == PH_READ || r_phase == PH_SLA_R_SENT)) begin
                        n_phase = PH_CLOSING;
                        em      = 1'b1;
                        em_cmd  = CMD_RX_NACK;
                    end else if (!r_fin_ret || r_fin_closing ||
                                 (r_phase == PH_WRITE && !r_fin_has_tx)) begin
                        n_slot_valid[r_head] = 1'b0;
                        n_head  = head_inc;
                        n_phase = PH_IDLE;
                        if (r_phase != PH_SLA_R && r_phase != PH_SLA_W) begin
                            em     = 1'b1;
                            em_cmd = CMD_STOP;
                        end
                    end else if (r_phase == PH_READ) begin
                        em     = 1'b1;
                        em_cmd = CMD_RX_ACK;
                    end else if (r_phase == PH_WRITE) begin
                        em      = 1'b1;
                        em_cmd  = CMD_SEND;
                        em_data = r_fin_txb;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer, control state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_pc          <= PC_DISPATCH;
            r_phase       <= PH_IDLE;
            r_slot_valid  <= '0;
            r_head        <= '0;
            r_instant     <= 1'b0;
            r_held_status <= 3'd0;
            r_held_nack   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (!r_busy && i_in_valid) begin
                r_busy <= 1'b1;
                r_pc   <= PC_DISPATCH;
            end else if (step_en) begin
                if (take) r_pc <= target;
                else r_busy <= 1'b0;
            end
            r_phase       <= n_phase;
            r_slot_valid  <= n_slot_valid;
            r_head        <= n_head;
            r_instant     <= n_instant;
            r_held_status <= n_held_status;
            r_held_nack   <= n_held_nack;
            if (em) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_in_valid) begin
            r_opcode      <= i_opcode;
            r_address     <= i_address;
            r_is_transmit <= i_is_transmit;
            r_tag         <= i_client_tag;
            r_bus_idle    <= i_bus_idle;
            r_bus_status  <= i_bus_status;
            r_rx_byte     <= i_rx_byte;
            r_keep        <= i_keep_going;
            r_has_tx      <= i_has_tx_byte;
            r_tx_byte     <= i_tx_byte;
        end
        r_scan_ptr    <= n_scan_ptr;
        r_scan_cnt    <= n_scan_cnt;
        r_fin_closing <= n_fin_closing;
        r_fin_ret     <= n_fin_ret;
        r_fin_nack    <= n_fin_nack;
        r_fin_has_tx  <= n_fin_has_tx;
        r_fin_txb     <= n_fin_txb;
        if (em) begin
            r_out_kind <= em_kind;
            r_out_acc  <= em_acc;
            r_out_tag  <= em_tag;
            r_out_st   <= em_st;
            r_out_data <= em_data;
            r_out_cmd  <= em_cmd;
        end
    end

    // Slot payload store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_addr_dir[wr_idx] <= wr_addr_dir;
            r_slot_client[wr_idx]   <= r_tag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_accepted      = r_out_acc;
    assign o_target_tag    = r_out_tag;
    assign o_client_status = r_out_st;
    assign o_data_byte     = r_out_data;
    assign o_bus_command   = r_out_cmd;
    // every item yields at most one beat, so each beat is the final one
    assign o_last          = 1'b1;

endmodule
